[sv/hbep_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// HID boot endpoint parser package
// Descriptor codes, field offsets and the result record shared by the design.
// ---------------------------------------------------------------------------
package hbep_pkg;

    // Configuration header checks.
    localparam logic [7:0] DESC_TYPE_CONFIG   = 8'd2;
    localparam int         HDR_TYPE_OFFSET    = 1;
    localparam int         CFG_VALUE_OFFSET   = 5;
    localparam int         MIN_SET_LEN        = 9;

    // Sub-descriptor walk.
    localparam logic [7:0] MIN_DESC_LEN       = 8'd2;
    localparam logic [7:0] BODY_FIRST_POS     = 8'd2;
    localparam logic [7:0] BODY_LAST_POS      = 8'd7;
    localparam int         BODY_DEPTH         = 6;
    localparam int         BODY_IDX_BITS      = $clog2(BODY_DEPTH);

    // Interface and endpoint descriptors.
    localparam logic [7:0] DESC_TYPE_IFACE    = 8'd4;
    localparam logic [7:0] DESC_TYPE_ENDPOINT = 8'd5;
    localparam logic [7:0] MIN_IFACE_LEN      = 8'd9;
    localparam logic [7:0] MIN_ENDPOINT_LEN   = 8'd7;
    localparam logic [7:0] HID_CLASS          = 8'd3;
    localparam logic [7:0] BOOT_SUBCLASS      = 8'd1;
    localparam logic [1:0] XFER_INTERRUPT     = 2'b11;
    localparam int         EP_DIR_BIT         = 7;

    localparam logic [7:0] TARGET_PROTOCOL_RESET = 8'd1;

    typedef struct packed {
        logic        found;
        logic [7:0]  configuration_value;
        logic [7:0]  interface_id;
        logic [7:0]  endpoint_address;
        logic [15:0] max_packet_size;
    } t_result;

endpackage

[sv/hbep_in_if.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Descriptor byte channel
// Valid/ready channel that carries one descriptor byte and its end flag.
// ---------------------------------------------------------------------------
interface hbep_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, output data_byte, output last, input ready);
    modport sink   (input valid, input data_byte, input last, output ready);
endinterface

[sv/hbep_res_if.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Parse result channel
// Valid/ready channel that carries one result of a descriptor set.
// ---------------------------------------------------------------------------
interface hbep_res_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [7:0]  configuration_value;
    logic [7:0]  interface_id;
    logic [7:0]  endpoint_address;
    logic [15:0] max_packet_size;

    modport source (output valid, output found, output configuration_value,
                    output interface_id, output endpoint_address,
                    output max_packet_size, input ready);
    modport sink   (input valid, input found, input configuration_value,
                    input interface_id, input endpoint_address,
                    input max_packet_size, output ready);
endinterface

[sv/hid_boot_endpoint_descriptor_parser_unit.sv]
`timescale 1ns / 1ps
// The last byte is registered in the input stage, then its result in the output stage.
// One beat per cycle except as below; the walker updates all of its state in one step.
// A held result stalls only the last byte of the next set; other bytes keep flowing.
// Reset (i_rst_n low, synchronous) empties both stages, clears the walk state and
// sets target_protocol to 1 (boot keyboard).
// ---------------------------------------------------------------------------
// HID boot endpoint descriptor parser
// Walks a USB configuration descriptor set byte by byte and reports the boot
// HID interrupt IN endpoint of the interface whose protocol matches.
// ---------------------------------------------------------------------------
module hid_boot_endpoint_descriptor_parser_unit #(
    parameter int COUNT_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [7:0]   i_cfg_wdata,
    hbep_in_if.sink      i_in,
    hbep_res_if.source   o_res
);
    import hbep_pkg::*;

    // Configuration register: the interface protocol being sought.
    logic [7:0] r_target_protocol;

    // Input stage: one registered byte beat waiting for the walker.
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // Output stage: one finished result waiting for the sink.
    logic    r_out_valid;
    t_result r_out;

    t_result walk_result;
    logic    out_free;
    logic    step;

    // The output slot is free when empty or being drained this cycle.
    assign out_free = !r_out_valid || o_res.ready;
    // A byte that ends the set needs room for its result; other bytes never wait.
    assign step = r_in_valid && (!r_in_last || out_free);
    assign i_in.ready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_protocol <= TARGET_PROTOCOL_RESET;
        end else if (i_cfg_we) begin
            r_target_protocol <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_byte <= i_in.data_byte;
            r_in_last <= i_in.last;
        end
    end

    hbep_walker #(
        .COUNT_BITS (COUNT_BITS)
    ) u_walker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_step            (step),
        .i_data_byte       (r_in_byte),
        .i_last            (r_in_last),
        .i_target_protocol (r_target_protocol),
        .o_result          (walk_result)
    );

    // The result of a set is captured on the step of its last byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && r_in_last) begin
            r_out <= walk_result;
        end
    end

    assign o_res.valid               = r_out_valid;
    assign o_res.found               = r_out.found;
    assign o_res.configuration_value = r_out.configuration_value;
    assign o_res.interface_id        = r_out.interface_id;
    assign o_res.endpoint_address    = r_out.endpoint_address;
    assign o_res.max_packet_size     = r_out.max_packet_size;

`ifndef SYNTHESIS
    a_found_fields_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.found |-> r_out.configuration_value != 8'd0 &&
        r_out.endpoint_address != 8'd0 && r_out.max_packet_size != 16'd0)
        else $error("found set with a zero field");

    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step && r_in_last |=> r_out_valid)
        else $error("last byte processed without a result");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_res.ready |-> !(step && r_in_last))
        else $error("result overwritten while held");

    a_input_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !step |=> r_in_valid && $stable(r_in_byte) && $stable(r_in_last))
        else $error("pending byte lost");
`endif

endmodule

[sv/hbep_walker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Descriptor walker
// Holds the walk state of one descriptor set and updates it one byte a step.
// ---------------------------------------------------------------------------
module hbep_walker #(
    parameter int COUNT_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [7:0]       i_data_byte,
    input  logic             i_last,
    input  logic [7:0]       i_target_protocol,
    output hbep_pkg::t_result o_result
);
    import hbep_pkg::*;

    logic [COUNT_BITS-1:0] r_byte_count, n_byte_count;
    logic [7:0]  r_desc_position, n_desc_position;
    logic [7:0]  r_desc_length, n_desc_length;
    logic [7:0]  r_desc_kind, n_desc_kind;
    logic [7:0]  r_desc_body [BODY_DEPTH];
    logic        r_walk_stopped, n_walk_stopped;
    logic        r_header_good, n_header_good;
    logic        r_iface_sel, n_iface_sel;
    logic [7:0]  r_cfg_seen, n_cfg_seen;
    logic [7:0]  r_iface_seen, n_iface_seen;
    logic [7:0]  r_ep_seen, n_ep_seen;
    logic [15:0] r_mps_seen, n_mps_seen;

    logic                     body_we;
    logic [7:0]               body_off;
    logic [BODY_IDX_BITS-1:0] body_idx;
    logic                     desc_done;
    logic                     set_ok;

    assign body_off = r_desc_position - BODY_FIRST_POS;
    assign body_idx = body_off[BODY_IDX_BITS-1:0];
    assign desc_done = ({1'b0, r_desc_position} + 9'd1) >= {1'b0, r_desc_length};

    always_comb begin
        n_byte_count    = r_byte_count;
        n_desc_position = r_desc_position;
        n_desc_length   = r_desc_length;
        n_desc_kind     = r_desc_kind;
        n_walk_stopped  = r_walk_stopped;
        n_header_good   = r_header_good;
        n_iface_sel     = r_iface_sel;
        n_cfg_seen      = r_cfg_seen;
        n_iface_seen    = r_iface_seen;
        n_ep_seen       = r_ep_seen;
        n_mps_seen      = r_mps_seen;
        body_we         = 1'b0;

        if (r_byte_count == COUNT_BITS'(HDR_TYPE_OFFSET)) begin
            n_header_good = (i_data_byte == DESC_TYPE_CONFIG);
        end
        if (r_byte_count == COUNT_BITS'(CFG_VALUE_OFFSET)) begin
            n_cfg_seen = i_data_byte;
        end

        if (!r_walk_stopped) begin
            if (r_desc_position == 8'd0) begin
                if (i_data_byte < MIN_DESC_LEN) begin
                    n_walk_stopped = 1'b1;
                end else begin
                    n_desc_length   = i_data_byte;
                    n_desc_position = 8'd1;
                end
            end else begin
                if (r_desc_position == 8'd1) begin
                    n_desc_kind = i_data_byte;
                end else if (r_desc_position <= BODY_LAST_POS) begin
                    body_we = 1'b1;
                end
                if (desc_done) begin
                    n_desc_position = 8'd0;
                    // The fields used below were all stored on earlier bytes.
                    if (r_desc_kind == DESC_TYPE_IFACE && r_desc_length >= MIN_IFACE_LEN) begin
                        n_iface_sel = (r_desc_body[3] == HID_CLASS) &&
                                      (r_desc_body[4] == BOOT_SUBCLASS) &&
                                      (r_desc_body[5] == i_target_protocol);
                        if (n_iface_sel) begin
                            n_iface_seen = r_desc_body[0];
                        end
                    end else if (r_desc_kind == DESC_TYPE_ENDPOINT &&
                                 r_desc_length >= MIN_ENDPOINT_LEN && r_iface_sel) begin
                        if (r_desc_body[1][1:0] == XFER_INTERRUPT &&
                            r_desc_body[0][EP_DIR_BIT]) begin
                            n_ep_seen  = r_desc_body[0];
                            n_mps_seen = {r_desc_body[3], r_desc_body[2]};
                        end
                    end
                end else begin
                    n_desc_position = r_desc_position + 8'd1;
                end
            end
        end

        if (r_byte_count != '1) begin
            n_byte_count = r_byte_count + COUNT_BITS'(1);
        end
    end

    // The result reflects the state after the current byte.
    assign set_ok = n_header_good && (n_byte_count >= COUNT_BITS'(MIN_SET_LEN));

    always_comb begin
        o_result.configuration_value = set_ok ? n_cfg_seen   : 8'd0;
        o_result.interface_id        = set_ok ? n_iface_seen : 8'd0;
        o_result.endpoint_address    = set_ok ? n_ep_seen    : 8'd0;
        o_result.max_packet_size     = set_ok ? n_mps_seen   : 16'd0;
        o_result.found = set_ok && (n_cfg_seen != 8'd0) && (n_ep_seen != 8'd0) &&
                         (n_mps_seen != 16'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last)) begin
            r_byte_count    <= '0;
            r_desc_position <= 8'd0;
            r_desc_length   <= 8'd0;
            r_desc_kind     <= 8'd0;
            r_walk_stopped  <= 1'b0;
            r_header_good   <= 1'b0;
            r_iface_sel     <= 1'b0;
            r_cfg_seen      <= 8'd0;
            r_iface_seen    <= 8'd0;
            r_ep_seen       <= 8'd0;
            r_mps_seen      <= 16'd0;
        end else if (i_step) begin
            r_byte_count    <= n_byte_count;
            r_desc_position <= n_desc_position;
            r_desc_length   <= n_desc_length;
            r_desc_kind     <= n_desc_kind;
            r_walk_stopped  <= n_walk_stopped;
            r_header_good   <= n_header_good;
            r_iface_sel     <= n_iface_sel;
            r_cfg_seen      <= n_cfg_seen;
            r_iface_seen    <= n_iface_seen;
            r_ep_seen       <= n_ep_seen;
            r_mps_seen      <= n_mps_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step && body_we) begin
            r_desc_body[body_idx] <= i_data_byte;
        end
    end

`ifndef SYNTHESIS
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_last |=> r_byte_count == '0 && !r_walk_stopped && !r_iface_sel)
        else $error("walk state not cleared after the last byte");

    a_position_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_desc_position != 8'd0 |-> r_desc_position < r_desc_length)
        else $error("descriptor position ran past its length");

    a_stopped_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_walk_stopped |-> r_desc_position == 8'd0)
        else $error("stopped walk inside a descriptor");
`endif

endmodule
